// File: design/adsr_pkg.sv
// Package for the three-voice ADSR envelope generator: constants, step tables, state entry type.
`default_nettype none

package adsr_pkg;

    localparam int DEFAULT_VOICES = 3;

    localparam int AMP_W   = 15;
    localparam int LEVEL_W = 7;
    localparam int STEP_W  = 13;
    localparam int ATK_W   = 14;
    localparam int RECIP_W = 29;
    localparam int PROD_W  = AMP_W + RECIP_W;

    localparam logic [AMP_W-1:0] TOP_LEVEL    = 15'd19000;
    localparam logic [10:0]      SUSTAIN_UNIT = 11'd1266;

    localparam logic [7:0] AD_RESET = 8'h00;
    localparam logic [7:0] SR_RESET = 8'hF0;

    localparam int unsigned ATK_MS [16] = '{
        2, 4, 16, 24, 38, 58, 68, 80, 100, 250, 500, 800, 1000, 3000, 5000, 8000
    };
    localparam int unsigned DR_MS [16] = '{
        6, 24, 48, 72, 114, 168, 204, 240, 300, 750, 1500, 2400, 3000, 9000, 15000, 24000
    };

    // Attack step is a fixed quotient of the top level
    localparam logic [ATK_W-1:0] ATK_STEP [16] = '{
        ATK_W'(TOP_LEVEL / ATK_MS[0]),  ATK_W'(TOP_LEVEL / ATK_MS[1]),
        ATK_W'(TOP_LEVEL / ATK_MS[2]),  ATK_W'(TOP_LEVEL / ATK_MS[3]),
        ATK_W'(TOP_LEVEL / ATK_MS[4]),  ATK_W'(TOP_LEVEL / ATK_MS[5]),
        ATK_W'(TOP_LEVEL / ATK_MS[6]),  ATK_W'(TOP_LEVEL / ATK_MS[7]),
        ATK_W'(TOP_LEVEL / ATK_MS[8]),  ATK_W'(TOP_LEVEL / ATK_MS[9]),
        ATK_W'(TOP_LEVEL / ATK_MS[10]), ATK_W'(TOP_LEVEL / ATK_MS[11]),
        ATK_W'(TOP_LEVEL / ATK_MS[12]), ATK_W'(TOP_LEVEL / ATK_MS[13]),
        ATK_W'(TOP_LEVEL / ATK_MS[14]), ATK_W'(TOP_LEVEL / ATK_MS[15])
    };

    // Reciprocals ceil(2^31 / ms); exact floor quotient for dividends below 2^31 / 24000
    localparam int               RECIP_SHIFT = 31;
    localparam longint unsigned  RECIP_ONE   = 64'h0000_0000_8000_0000;
    localparam logic [RECIP_W-1:0] DR_RECIP [16] = '{
        RECIP_W'((RECIP_ONE + DR_MS[0]  - 1) / DR_MS[0]),
        RECIP_W'((RECIP_ONE + DR_MS[1]  - 1) / DR_MS[1]),
        RECIP_W'((RECIP_ONE + DR_MS[2]  - 1) / DR_MS[2]),
        RECIP_W'((RECIP_ONE + DR_MS[3]  - 1) / DR_MS[3]),
        RECIP_W'((RECIP_ONE + DR_MS[4]  - 1) / DR_MS[4]),
        RECIP_W'((RECIP_ONE + DR_MS[5]  - 1) / DR_MS[5]),
        RECIP_W'((RECIP_ONE + DR_MS[6]  - 1) / DR_MS[6]),
        RECIP_W'((RECIP_ONE + DR_MS[7]  - 1) / DR_MS[7]),
        RECIP_W'((RECIP_ONE + DR_MS[8]  - 1) / DR_MS[8]),
        RECIP_W'((RECIP_ONE + DR_MS[9]  - 1) / DR_MS[9]),
        RECIP_W'((RECIP_ONE + DR_MS[10] - 1) / DR_MS[10]),
        RECIP_W'((RECIP_ONE + DR_MS[11] - 1) / DR_MS[11]),
        RECIP_W'((RECIP_ONE + DR_MS[12] - 1) / DR_MS[12]),
        RECIP_W'((RECIP_ONE + DR_MS[13] - 1) / DR_MS[13]),
        RECIP_W'((RECIP_ONE + DR_MS[14] - 1) / DR_MS[14]),
        RECIP_W'((RECIP_ONE + DR_MS[15] - 1) / DR_MS[15])
    };

    typedef struct packed {
        logic             in_attack;
        logic [AMP_W-1:0] amp;
    } amp_entry_t;

endpackage

`default_nettype wire

// File: design/adsr_envelope_three_voice.sv
// Top level of the multi-voice linear ADSR envelope generator.
//
//  channel   dir  handshake                     content
//  s_*       in   s_tvalid/s_tready             one tick: gate bit per voice
//  m_*       out  m_tvalid/m_tready             envelope level per voice
//  apb       in   psel/penable/pwrite/pready    attack/decay, sustain/release per voice
//
// Voices go one per cycle through a read-modify-write of the amplitude memory; a new tick can be
// accepted while the last voice of the previous one issues.
// At most two ticks are outstanding and s_tready drops until the older one transfers out.
// Reset clears all voices to amplitude zero with attack armed (valid bits, no sweep).
// A write forwarding register covers a read of a voice written in the previous cycle.
`default_nettype none

module adsr_envelope_three_voice
    import adsr_pkg::*;
#(
    parameter int VOICES = DEFAULT_VOICES,
    localparam int S_DATA_W = ((VOICES + 7) / 8) * 8,
    localparam int M_DATA_W = ((LEVEL_W * VOICES + 7) / 8) * 8,
    localparam int ADDR_W   = $clog2(8 * VOICES)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // gate_voice0, gate_voice1, ... one bit each

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // level_voice0, level_voice1, ... 7 bits each

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int VW       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IW       = ADDR_W - 2;
    localparam int NUM_REGS = 2 * VOICES;
    localparam int COLL_W   = LEVEL_W * VOICES;

    // configuration registers
    logic [7:0]   ad_reg [VOICES];
    logic [7:0]   sr_reg [VOICES];
    logic [VOICES-1:0] rearm_reg;
    logic [VOICES-1:0] valid_reg;

    // issue stage
    logic              busy_reg;
    logic [VW-1:0]     voice_reg;
    logic [VOICES-1:0] gates_reg;
    logic [1:0]        outstanding_reg;

    // update stage
    logic              s1_valid_reg;
    logic [VW-1:0]     s1_voice_reg;
    logic              s1_gate_reg;
    logic [AMP_W-1:0]  s1_sus_reg;
    logic [ATK_W-1:0]  s1_atk_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    amp_entry_t        rd_reg;

    amp_entry_t        fwd_entry_reg;
    logic              fwd_valid_reg;
    logic [VW-1:0]     fwd_voice_reg;

    amp_entry_t        amp_mem [VOICES];

    logic [COLL_W-1:0] coll_reg;
    logic              coll_full_reg;
    logic              m_tvalid_reg;
    logic [COLL_W-1:0] m_data_reg;

    // configuration decode
    logic          cfg_wr;
    logic [IW-1:0] cfg_idx;
    logic [VW-1:0] cfg_voice;
    logic          cfg_hit;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_voice = VW'(cfg_idx >> 1);
    assign cfg_hit   = (32'(cfg_idx) < 32'(NUM_REGS));

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            if (cfg_idx[0])
                prdata = 32'(sr_reg[cfg_voice]);
            else
                prdata = 32'(ad_reg[cfg_voice]);
        end
    end

    // handshake
    logic last_issue;
    logic accept;
    logic out_xfer;

    assign last_issue = busy_reg && (voice_reg == VW'(VOICES - 1));
    assign s_tready   = (!busy_reg || last_issue) && (outstanding_reg < 2'd2);
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = M_DATA_W'(m_data_reg);
    assign out_xfer   = m_tvalid_reg && m_tready;

    // issue stage operands
    logic [7:0]         iss_ad;
    logic [7:0]         iss_sr;
    logic               iss_gate;
    logic [AMP_W-1:0]   iss_sus;
    logic [AMP_W-1:0]   iss_dividend;
    logic [RECIP_W-1:0] iss_recip;

    always_comb
    begin
        iss_ad       = ad_reg[voice_reg];
        iss_sr       = sr_reg[voice_reg];
        iss_gate     = gates_reg[voice_reg];
        iss_sus      = AMP_W'(iss_sr[7:4] * SUSTAIN_UNIT);
        iss_dividend = iss_gate ? (TOP_LEVEL - iss_sus) : iss_sus;
        iss_recip    = iss_gate ? DR_RECIP[iss_ad[3:0]] : DR_RECIP[iss_sr[3:0]];
    end

    // update stage
    logic              fwd_hit;
    amp_entry_t        cur_entry;
    logic              cur_attack;
    logic [STEP_W-1:0] dr_step;
    logic [AMP_W:0]    atk_sum;
    logic [AMP_W-1:0]  above_sus;
    amp_entry_t        new_entry;
    logic              last_write;

    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_voice_reg == s1_voice_reg);
        if (fwd_hit)
            cur_entry = fwd_entry_reg;
        else if (valid_reg[s1_voice_reg])
            cur_entry = rd_reg;
        else
        begin
            cur_entry.in_attack = 1'b1;
            cur_entry.amp       = '0;
        end
        cur_attack = cur_entry.in_attack || rearm_reg[s1_voice_reg];
        dr_step    = s1_prod_reg[RECIP_SHIFT +: STEP_W];
        atk_sum    = {1'b0, cur_entry.amp} + (AMP_W + 1)'(s1_atk_reg);
        above_sus  = cur_entry.amp - s1_sus_reg;

        new_entry.in_attack = cur_attack;
        new_entry.amp       = cur_entry.amp;
        if (s1_gate_reg)
        begin
            if (cur_attack)
            begin
                if (atk_sum > (AMP_W + 1)'(TOP_LEVEL))
                begin
                    new_entry.amp       = TOP_LEVEL;
                    new_entry.in_attack = 1'b0;
                end
                else
                    new_entry.amp = atk_sum[AMP_W-1:0];
            end
            else if (cur_entry.amp > s1_sus_reg)
            begin
                // clamp at the sustain level
                if (AMP_W'(dr_step) >= above_sus)
                    new_entry.amp = s1_sus_reg;
                else
                    new_entry.amp = cur_entry.amp - AMP_W'(dr_step);
            end
        end
        else
        begin
            new_entry.in_attack = 1'b1;
            if (AMP_W'(dr_step) >= cur_entry.amp)
                new_entry.amp = '0;
            else
                new_entry.amp = cur_entry.amp - AMP_W'(dr_step);
        end
        last_write = s1_valid_reg && (s1_voice_reg == VW'(VOICES - 1));
    end

    // amplitude memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            amp_mem[s1_voice_reg] <= new_entry;
        if (busy_reg)
            rd_reg <= amp_mem[voice_reg];
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept)
            gates_reg <= s_tdata[VOICES-1:0];
        if (busy_reg)
        begin
            s1_voice_reg <= voice_reg;
            s1_gate_reg  <= iss_gate;
            s1_sus_reg   <= iss_sus;
            s1_atk_reg   <= ATK_STEP[iss_ad[7:4]];
            s1_prod_reg  <= PROD_W'(iss_dividend) * PROD_W'(iss_recip);
        end
        fwd_voice_reg <= s1_voice_reg;
        fwd_entry_reg <= new_entry;
        if (s1_valid_reg)
            coll_reg[s1_voice_reg * LEVEL_W +: LEVEL_W] <= new_entry.amp[AMP_W-1:8];
        if (coll_full_reg && (!m_tvalid_reg || m_tready))
            m_data_reg <= coll_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                ad_reg[v] <= AD_RESET;
                sr_reg[v] <= SR_RESET;
            end
            rearm_reg       <= '0;
            valid_reg       <= '0;
            busy_reg        <= 1'b0;
            voice_reg       <= '0;
            outstanding_reg <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            coll_full_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            // issue sequencer
            if (accept)
            begin
                busy_reg  <= 1'b1;
                voice_reg <= '0;
            end
            else if (last_issue)
                busy_reg <= 1'b0;
            else if (busy_reg)
                voice_reg <= voice_reg + 1'b1;

            outstanding_reg <= outstanding_reg + 2'(accept) - 2'(out_xfer);

            s1_valid_reg  <= busy_reg;
            fwd_valid_reg <= s1_valid_reg;

            if (s1_valid_reg)
            begin
                valid_reg[s1_voice_reg] <= 1'b1;
                rearm_reg[s1_voice_reg] <= 1'b0;
            end

            // hand the finished tick to the output register
            if (coll_full_reg && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg  <= 1'b1;
                coll_full_reg <= last_write;
            end
            else
            begin
                if (out_xfer)
                    m_tvalid_reg <= 1'b0;
                if (last_write)
                    coll_full_reg <= 1'b1;
            end

            if (cfg_wr && cfg_hit)
            begin
                if (cfg_idx[0])
                    sr_reg[cfg_voice] <= pwdata[7:0];
                else
                    ad_reg[cfg_voice] <= pwdata[7:0];
                rearm_reg[cfg_voice] <= 1'b1;
            end
        end
    end

    a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 2'd2)
        else $error("more than two ticks outstanding");

    a_coll_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (coll_full_reg && !m_tvalid_reg && !last_write) |=> !coll_full_reg)
        else $error("finished tick not moved to an empty output register");

    a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg || coll_full_reg) |-> (outstanding_reg != 2'd0))
        else $error("result held with no tick outstanding");

endmodule

`default_nettype wire
